/* rtl/itl_pkg.sv */
// Package for the interval table: sizes, command and status codes, word types.
// Used by itl_cell and interval_table_with_point_lookup; depends on nothing.
package itl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int HANDLE_BITS   = 16;

    localparam int TIME_W   = 31;
    localparam int HANDLE_W = HANDLE_BITS;
    localparam int SLOT_W   = $clog2(TABLE_ENTRIES);
    localparam int COUNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDIT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEEK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PAST_END = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVL_NEXT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVL_PREV = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [TIME_W-1:0]   begin_time;
        logic [TIME_W-1:0]   length_ms;
        logic [HANDLE_W-1:0] payload_handle;
        logic [TIME_W-1:0]   seek_position;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                on_interval;
        logic [HANDLE_W-1:0] found_handle;
        logic [TIME_W-1:0]   found_begin;
        logic [TIME_W-1:0]   found_length;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_word;

    // Search word that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   key;
        logic                skip_en;
        logic [SLOT_W-1:0]   skip_slot;
        logic                have_next;
        logic [TIME_W-1:0]   next_begin;
        logic                have_prev;
        logic [TIME_W-1:0]   prev_begin;
        logic [TIME_W-1:0]   prev_length;
        logic [HANDLE_W-1:0] prev_handle;
        logic [SLOT_W-1:0]   prev_slot;
        logic                have_free;
        logic [SLOT_W-1:0]   free_slot;
    } t_sweep;

    // Entry write broadcast to every cell.
    typedef struct packed {
        logic                en;
        logic                set_entry;
        logic [SLOT_W-1:0]   slot;
        logic [TIME_W-1:0]   begin_time;
        logic [TIME_W-1:0]   length_ms;
        logic [HANDLE_W-1:0] handle;
    } t_wr;

endpackage

/* rtl/itl_cell.sv */
// One table slot of the interval table plus one stage of the search word.
// Depends on itl_pkg.
module itl_cell import itl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  t_wr               i_wr,
    input  t_sweep            i_word,
    output t_sweep            o_word
);

    logic                r_valid;
    logic [TIME_W-1:0]   r_begin;
    logic [TIME_W-1:0]   r_length;
    logic [HANDLE_W-1:0] r_handle;
    t_sweep              r_word;
    t_sweep              n_word;
    logic                hit;
    logic                wr_sel;

    assign wr_sel = i_wr.en && (i_wr.slot == i_idx);
    assign hit    = r_valid && !(i_word.skip_en && (i_word.skip_slot == i_idx));

    // Fold this slot into the running next / previous / free search.
    always_comb begin
        n_word = i_word;
        if (i_word.valid) begin
            if (hit) begin
                if (r_begin > i_word.key) begin
                    if (!i_word.have_next || (r_begin < i_word.next_begin)) begin
                        n_word.have_next  = 1'b1;
                        n_word.next_begin = r_begin;
                    end
                end else if (!i_word.have_prev || (r_begin > i_word.prev_begin)) begin
                    n_word.have_prev   = 1'b1;
                    n_word.prev_begin  = r_begin;
                    n_word.prev_length = r_length;
                    n_word.prev_handle = r_handle;
                    n_word.prev_slot   = i_idx;
                end
            end
            if (!r_valid && !i_word.have_free) begin
                n_word.have_free = 1'b1;
                n_word.free_slot = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_word.valid <= 1'b0;
        end else begin
            r_word <= n_word;
            if (wr_sel) begin
                r_valid <= i_wr.set_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_sel && i_wr.set_entry) begin
            r_begin  <= i_wr.begin_time;
            r_length <= i_wr.length_ms;
            r_handle <= i_wr.handle;
        end
    end

    assign o_word = r_word;

endmodule

/* rtl/interval_table_with_point_lookup.sv */
// Top level of the interval table with point lookup: command sequencer and row of cells.
// Depends on itl_pkg and itl_cell.
//
// The block holds up to TABLE_ENTRIES non-overlapping intervals (begin, length,
// handle) and a current position, and answers one result word per command word.
// Each slot lives in its own cell; a search word enters the first cell and moves
// one cell per cycle down the row, collecting the nearest stored begin above a
// key, the largest stored begin at or below it, and the first free slot. A seek,
// or an edit or remove with nothing found, makes one pass (the point lookup),
// then the result is registered. A remove of a found entry first clears its slot
// and then runs the lookup pass. An add or an edit makes a check pass, writes the
// slot, then runs the lookup pass; a rejected add or edit skips the write. The
// result waits in the finish state until the output register frees up. One command
// is in work at a time; the next command word is taken as soon as the previous
// result sits in the output register, even while that result waits for i_ready.
// media_length is written through i_cfg_we / i_cfg_data and must only change
// while the block is idle. Stored begins are unique, so ties never arise.
module interval_table_with_point_lookup import itl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TIME_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in_word          i_in,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out_word         o_rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_LOOK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [TIME_W-1:0]   r_media, n_media;
    logic [TIME_W-1:0]   r_pos, n_pos;
    t_in_word            r_cmd, n_cmd;
    logic [STATUS_W-1:0] r_status, n_status;
    t_wr                 r_wr, n_wr;
    t_sweep              r_launch, n_launch;
    logic                r_found_valid, n_found_valid;
    logic [SLOT_W-1:0]   r_found_slot, n_found_slot;
    logic [TIME_W-1:0]   r_found_begin, n_found_begin;
    logic [TIME_W-1:0]   r_found_length, n_found_length;
    logic [HANDLE_W-1:0] r_found_handle, n_found_handle;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out, n_out;

    t_sweep              w_word [0:TABLE_ENTRIES];
    t_sweep              w_tail;
    logic                in_acc;
    logic [TIME_W:0]     c_end;
    logic [TIME_W:0]     c_prev_end;
    logic [STATUS_W-1:0] c_chk_status;
    logic                c_hit;

    function automatic t_sweep mk_sweep(input logic [TIME_W-1:0] key,
                                        input logic              skip_en,
                                        input logic [SLOT_W-1:0] skip_slot);
        t_sweep w;
        w           = '0;
        w.valid     = 1'b1;
        w.key       = key;
        w.skip_en   = skip_en;
        w.skip_slot = skip_slot;
        return w;
    endfunction

    // Row of cells; the launch register feeds the head.
    assign w_word[0] = r_launch;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        itl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_wr    (r_wr),
            .i_word  (w_word[g]),
            .o_word  (w_word[g+1])
        );
    end

    assign w_tail = w_word[TABLE_ENTRIES];

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // End of the candidate and of the previous stored interval, without wrap.
    assign c_end      = {1'b0, r_cmd.begin_time} + {1'b0, r_cmd.length_ms};
    assign c_prev_end = {1'b0, w_tail.prev_begin} + {1'b0, w_tail.prev_length};
    assign c_hit      = w_tail.have_prev && (c_prev_end > {1'b0, r_pos});

    // Check order: media end, following interval, previous interval, room.
    always_comb begin
        priority if (c_end > {1'b0, r_media}) begin
            c_chk_status = ST_PAST_END;
        end else if (w_tail.have_next && (c_end > {1'b0, w_tail.next_begin})) begin
            c_chk_status = ST_OVL_NEXT;
        end else if (w_tail.have_prev && ((w_tail.prev_begin == r_cmd.begin_time) ||
                     (c_prev_end > {1'b0, r_cmd.begin_time}))) begin
            c_chk_status = ST_OVL_PREV;
        end else if ((r_cmd.command == CMD_ADD) && !w_tail.have_free) begin
            c_chk_status = ST_FULL;
        end else begin
            c_chk_status = ST_OK;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_media        = i_cfg_we ? i_cfg_data : r_media;
        n_pos          = r_pos;
        n_cmd          = r_cmd;
        n_status       = r_status;
        n_wr           = r_wr;
        n_launch       = r_launch;
        n_launch.valid = 1'b0;
        n_found_valid  = r_found_valid;
        n_found_slot   = r_found_slot;
        n_found_begin  = r_found_begin;
        n_found_length = r_found_length;
        n_found_handle = r_found_handle;
        n_count        = r_count;
        n_out_valid    = r_out_valid;
        n_out          = r_out;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd    = i_in;
                    n_status = ST_OK;
                    unique case (i_in.command)
                        CMD_ADD: begin
                            n_launch = mk_sweep(i_in.begin_time, 1'b0, '0);
                            n_state  = S_CHECK;
                        end
                        CMD_EDIT: begin
                            if (r_found_valid) begin
                                n_launch = mk_sweep(i_in.begin_time, 1'b1, r_found_slot);
                                n_state  = S_CHECK;
                            end else begin
                                n_status = ST_NONE;
                                n_launch = mk_sweep(r_pos, 1'b0, '0);
                                n_state  = S_LOOK;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_found_valid) begin
                                n_wr.en        = 1'b1;
                                n_wr.set_entry = 1'b0;
                                n_wr.slot      = r_found_slot;
                                n_count        = r_count - COUNT_W'(1);
                                n_state        = S_WRITE;
                            end else begin
                                n_status = ST_NONE;
                                n_launch = mk_sweep(r_pos, 1'b0, '0);
                                n_state  = S_LOOK;
                            end
                        end
                        CMD_SEEK: begin
                            n_pos    = i_in.seek_position;
                            n_launch = mk_sweep(i_in.seek_position, 1'b0, '0);
                            n_state  = S_LOOK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (w_tail.valid) begin
                    n_status = c_chk_status;
                    if (c_chk_status == ST_OK) begin
                        n_wr.en         = 1'b1;
                        n_wr.set_entry  = 1'b1;
                        n_wr.begin_time = r_cmd.begin_time;
                        n_wr.length_ms  = r_cmd.length_ms;
                        n_wr.handle     = r_cmd.payload_handle;
                        if (r_cmd.command == CMD_ADD) begin
                            n_wr.slot = w_tail.free_slot;
                            n_count   = r_count + COUNT_W'(1);
                        end else begin
                            n_wr.slot = r_found_slot;
                        end
                        n_state = S_WRITE;
                    end else begin
                        n_launch = mk_sweep(r_pos, 1'b0, '0);
                        n_state  = S_LOOK;
                    end
                end
            end
            S_WRITE: begin
                // Cells take the write at this edge; the lookup enters after it.
                n_wr.en  = 1'b0;
                n_launch = mk_sweep(r_pos, 1'b0, '0);
                n_state  = S_LOOK;
            end
            S_LOOK: begin
                if (w_tail.valid) begin
                    n_found_valid  = c_hit;
                    n_found_slot   = c_hit ? w_tail.prev_slot : r_found_slot;
                    n_found_begin  = w_tail.prev_begin;
                    n_found_length = w_tail.prev_length;
                    n_found_handle = w_tail.prev_handle;
                    n_state        = S_FINISH;
                end
            end
            S_FINISH: begin
                // Hold the result until the output register frees up.
                if (!r_out_valid || i_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_status;
                    n_out.on_interval  = r_found_valid;
                    n_out.found_handle = r_found_valid ? r_found_handle : '0;
                    n_out.found_begin  = r_found_valid ? r_found_begin : '0;
                    n_out.found_length = r_found_valid ? r_found_length : '0;
                    n_out.entry_count  = r_count;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_media        <= '0;
            r_pos          <= '0;
            r_wr.en        <= 1'b0;
            r_launch.valid <= 1'b0;
            r_found_valid  <= 1'b0;
            r_found_slot   <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_media       <= n_media;
            r_pos         <= n_pos;
            r_wr          <= n_wr;
            r_launch      <= n_launch;
            r_found_valid <= n_found_valid;
            r_found_slot  <= n_found_slot;
            r_count       <= n_count;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_status       <= n_status;
        r_found_begin  <= n_found_begin;
        r_found_length <= n_found_length;
        r_found_handle <= n_found_handle;
        r_out          <= n_out;
    end

    a_wr_only_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr.en |-> (r_state == S_WRITE))
        else $error("entry write outside the write state");

    a_tail_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> ((r_state == S_CHECK) || (r_state == S_LOOK)))
        else $error("search word left the row with no pass waiting");

    a_single_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch.valid |=> !r_launch.valid)
        else $error("two search words launched back to back");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_found_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && r_found_valid) |-> (r_count != '0))
        else $error("interval found in an empty table");

endmodule
